FILE: rtl/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared types, constants and helpers of the UDP/IPv4 frame checker.
// ----------------------------------------------------------------------------
package ufc_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] UDP_PROTOCOL   = 16'd17;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam int          ETH_HDR_LEN    = 14;
  localparam int          IP_MIN_HDR     = 20;
  localparam int          UDP_HDR_LEN    = 8;
  localparam int          MIN_FRAME_LEN  = ETH_HDR_LEN + IP_MIN_HDR + UDP_HDR_LEN;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_IPV4 = 3'd2,
    ST_BAD_IHL  = 3'd3,
    ST_IP_SUM   = 3'd4,
    ST_UDP_LEN  = 3'd5,
    ST_UDP_SUM  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] source_port;
    logic [31:0] source_address;
    logic [6:0]  payload_offset;
    logic [15:0] payload_length;
  } result_t;

  // everything gathered over one frame, as it stands after the final byte
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] ether_kind;
    logic [5:0]  header_bytes;
    logic [15:0] ip_sum_acc;
    logic [15:0] udp_sum_acc;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_udp_port;
    logic [15:0] udp_total_len;
    logic [15:0] stored_udp_sum;
    logic [7:0]  odd_byte_hold;
  } frame_sum_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/ufc_parse.sv
// ----------------------------------------------------------------------------
// ufc_parse
// Per-byte field capture and checksum accumulation; hands a frame summary
// to the judge stage at the final byte and clears for the next frame.
// ----------------------------------------------------------------------------
module ufc_parse import ufc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       sum_valid,
  input  logic       sum_ready,
  output frame_sum_t sum
);

  logic [15:0] byte_count;
  logic [15:0] ether_kind, ether_kind_next;
  logic [5:0]  header_bytes, header_bytes_next;
  logic [15:0] ip_sum_acc, ip_sum_acc_next;
  logic [15:0] udp_sum_acc, udp_sum_acc_next;
  logic [31:0] src_ip, src_ip_next;
  logic [31:0] dst_ip, dst_ip_next;
  logic [15:0] src_udp_port, src_udp_port_next;
  logic [15:0] udp_total_len, udp_total_len_next;
  logic [15:0] stored_udp_sum, stored_udp_sum_next;
  logic [7:0]  odd_byte_hold, odd_byte_hold_next;

  logic        fire;
  logic [7:0]  b;
  logic [15:0] pos;
  logic [16:0] ip_end;
  logic        in_ip, in_udp;
  logic [15:0] k;
  logic [7:0]  v;

  assign fire       = byte_valid && byte_ready;
  assign byte_ready = !sum_valid || sum_ready;
  assign b          = byte_item.data_byte;
  assign pos        = byte_count;

  always_comb begin
    ether_kind_next     = ether_kind;
    header_bytes_next   = header_bytes;
    ip_sum_acc_next     = ip_sum_acc;
    udp_sum_acc_next    = udp_sum_acc;
    src_ip_next         = src_ip;
    dst_ip_next         = dst_ip;
    src_udp_port_next   = src_udp_port;
    udp_total_len_next  = udp_total_len;
    stored_udp_sum_next = stored_udp_sum;
    odd_byte_hold_next  = odd_byte_hold;
    v                   = b;

    if (pos == 16'd12) begin
      ether_kind_next = {b, 8'h00};
    end else if (pos == 16'd13) begin
      ether_kind_next = ether_kind | {8'h00, b};
    end
    if (pos == 16'(ETH_HDR_LEN)) begin
      header_bytes_next = {b[3:0], 2'b00};
    end

    // header length takes effect on the byte that carries it
    ip_end = 17'(ETH_HDR_LEN) + {11'd0, header_bytes_next};
    in_ip  = (pos >= 16'(ETH_HDR_LEN)) && ({1'b0, pos} < ip_end);
    in_udp = !in_ip && (header_bytes_next >= 6'(IP_MIN_HDR)) && ({1'b0, pos} >= ip_end);
    k      = pos - ip_end[15:0];

    if (in_ip) begin
      // word parity follows pos, since the header starts on an even offset
      if (!pos[0]) begin
        odd_byte_hold_next = b;
      end else begin
        ip_sum_acc_next = oc_add(ip_sum_acc, {odd_byte_hold, b});
      end
      if (pos >= 16'd26 && pos < 16'd30) begin
        src_ip_next = {src_ip[23:0], b};
      end else if (pos >= 16'd30 && pos < 16'd34) begin
        dst_ip_next = {dst_ip[23:0], b};
      end
    end else if (in_udp) begin
      unique case (k)
        16'd0: src_udp_port_next = {b, 8'h00};
        16'd1: src_udp_port_next = src_udp_port | {8'h00, b};
        16'd4: udp_total_len_next = {b, 8'h00};
        16'd5: udp_total_len_next = udp_total_len | {8'h00, b};
        16'd6: begin
          stored_udp_sum_next = {b, 8'h00};
          v = 8'h00;
        end
        16'd7: begin
          stored_udp_sum_next = stored_udp_sum | {8'h00, b};
          v = 8'h00;
        end
        default: ;
      endcase
      // bytes past the udp length are padding
      if (k < 16'd6 || k < udp_total_len_next) begin
        if (!pos[0]) begin
          odd_byte_hold_next = v;
        end else begin
          udp_sum_acc_next = oc_add(udp_sum_acc, {odd_byte_hold, v});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      ether_kind     <= '0;
      header_bytes   <= '0;
      ip_sum_acc     <= '0;
      udp_sum_acc    <= '0;
      src_ip         <= '0;
      dst_ip         <= '0;
      src_udp_port   <= '0;
      udp_total_len  <= '0;
      stored_udp_sum <= '0;
      odd_byte_hold  <= '0;
      sum_valid      <= 1'b0;
    end else begin
      if (sum_valid && sum_ready) begin
        sum_valid <= 1'b0;
      end
      if (fire) begin
        if (byte_item.last) begin
          sum_valid      <= 1'b1;
          byte_count     <= '0;
          ether_kind     <= '0;
          header_bytes   <= '0;
          ip_sum_acc     <= '0;
          udp_sum_acc    <= '0;
          src_ip         <= '0;
          dst_ip         <= '0;
          src_udp_port   <= '0;
          udp_total_len  <= '0;
          stored_udp_sum <= '0;
          odd_byte_hold  <= '0;
        end else begin
          if (byte_count != COUNT_MAX) begin
            byte_count <= byte_count + 16'd1;
          end
          ether_kind     <= ether_kind_next;
          header_bytes   <= header_bytes_next;
          ip_sum_acc     <= ip_sum_acc_next;
          udp_sum_acc    <= udp_sum_acc_next;
          src_ip         <= src_ip_next;
          dst_ip         <= dst_ip_next;
          src_udp_port   <= src_udp_port_next;
          udp_total_len  <= udp_total_len_next;
          stored_udp_sum <= stored_udp_sum_next;
          odd_byte_hold  <= odd_byte_hold_next;
        end
      end
    end
  end

  // frame summary register
  always_ff @(posedge clk) begin
    if (fire && byte_item.last) begin
      sum.pos            <= pos;
      sum.ether_kind     <= ether_kind_next;
      sum.header_bytes   <= header_bytes_next;
      sum.ip_sum_acc     <= ip_sum_acc_next;
      sum.udp_sum_acc    <= udp_sum_acc_next;
      sum.src_ip         <= src_ip_next;
      sum.dst_ip         <= dst_ip_next;
      sum.src_udp_port   <= src_udp_port_next;
      sum.udp_total_len  <= udp_total_len_next;
      sum.stored_udp_sum <= stored_udp_sum_next;
      sum.odd_byte_hold  <= odd_byte_hold_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && byte_item.last |=> byte_count == 16'd0 && sum_valid)
    else $error("frame state not cleared after final byte");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    fire && !byte_item.last && byte_count != COUNT_MAX
    |=> byte_count == $past(byte_count) + 16'd1)
    else $error("byte count did not advance by one");

endmodule

FILE: rtl/ufc_judge.sv
// ----------------------------------------------------------------------------
// ufc_judge
// Two-stage verdict on a frame summary: length and header checks plus the
// pseudo-header partial sums, then the udp checksum compare and result.
// ----------------------------------------------------------------------------
module ufc_judge import ufc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sum_valid,
  output logic       sum_ready,
  input  frame_sum_t sum,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  // check stage
  logic        chk_valid;
  status_t     chk_status, chk_status_next;
  logic [17:0] chk_sum_a, chk_sum_b;
  logic [15:0] chk_port;
  logic [31:0] chk_src_ip;
  logic [5:0]  chk_hb;
  logic [15:0] chk_utl;
  logic [15:0] chk_stored;

  logic        out_adv;
  logic [16:0] pos_w, hb_w, utl_w;
  logic [15:0] pad_word;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2, calc;
  status_t     final_status;
  result_t     result_next;

  assign out_adv   = chk_valid && (!result_valid || result_ready);
  assign sum_ready = !chk_valid || out_adv;

  assign pos_w    = {1'b0, sum.pos};
  assign hb_w     = {11'd0, sum.header_bytes};
  assign utl_w    = {1'b0, sum.udp_total_len};
  assign pad_word = sum.udp_total_len[0] ? {sum.odd_byte_hold, 8'h00} : 16'h0000;

  always_comb begin
    priority if (sum.pos == COUNT_MAX || pos_w < 17'(MIN_FRAME_LEN - 1)) begin
      chk_status_next = ST_SHORT;
    end else if (sum.ether_kind != ETHERTYPE_IPV4) begin
      chk_status_next = ST_NOT_IPV4;
    end else if (sum.header_bytes < 6'(IP_MIN_HDR) ||
                 pos_w < 17'(ETH_HDR_LEN + UDP_HDR_LEN - 1) + hb_w) begin
      chk_status_next = ST_BAD_IHL;
    end else if (sum.ip_sum_acc != 16'hFFFF) begin
      chk_status_next = ST_IP_SUM;
    end else if (sum.udp_total_len < 16'(UDP_HDR_LEN) ||
                 17'(ETH_HDR_LEN - 1) + hb_w + utl_w > pos_w) begin
      chk_status_next = ST_UDP_LEN;
    end else begin
      chk_status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (sum_ready) begin
      chk_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      chk_status <= chk_status_next;
      chk_sum_a  <= {2'b00, sum.udp_sum_acc} + {2'b00, pad_word}
                  + {2'b00, sum.src_ip[31:16]} + {2'b00, sum.src_ip[15:0]};
      chk_sum_b  <= {2'b00, sum.dst_ip[31:16]} + {2'b00, sum.dst_ip[15:0]}
                  + {2'b00, UDP_PROTOCOL} + {2'b00, sum.udp_total_len};
      chk_port   <= sum.src_udp_port;
      chk_src_ip <= sum.src_ip;
      chk_hb     <= sum.header_bytes;
      chk_utl    <= sum.udp_total_len;
      chk_stored <= sum.stored_udp_sum;
    end
  end

  // fold of the whole sum matches the word-by-word end-around adds
  always_comb begin
    total = {1'b0, chk_sum_a} + {1'b0, chk_sum_b};
    fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    calc  = ~fold2;
    if (calc == 16'h0000) begin
      calc = 16'hFFFF;
    end
    if (chk_status == ST_OK && chk_stored != 16'h0000 && calc != chk_stored) begin
      final_status = ST_UDP_SUM;
    end else begin
      final_status = chk_status;
    end
    result_next.status = final_status;
    if (final_status == ST_OK) begin
      result_next.source_port    = chk_port;
      result_next.source_address = chk_src_ip;
      result_next.payload_offset = 7'(ETH_HDR_LEN + UDP_HDR_LEN) + {1'b0, chk_hb};
      result_next.payload_length = chk_utl - 16'(UDP_HDR_LEN);
    end else begin
      result_next.source_port    = '0;
      result_next.source_address = '0;
      result_next.payload_offset = '0;
      result_next.payload_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= chk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      result <= result_next;
    end
  end

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK
    |-> result.source_port == 16'd0 && result.source_address == 32'd0 &&
        result.payload_offset == 7'd0 && result.payload_length == 16'd0)
    else $error("error result carries nonzero fields");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK
    |-> result.payload_offset >= 7'd42 && result.payload_offset <= 7'd82)
    else $error("payload offset out of range on good frame");

endmodule

FILE: rtl/udp_ipv4_frame_checker.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_checker
// Receive-side check of Ethernet II / IPv4 / UDP frames with checksums.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while byte_ready is high, starting at the
// destination MAC, with last set on the final byte, and returns one result
// per frame: a status code and, for a good frame, the UDP source port, IPv4
// source address, payload offset and payload length. A byte transfer can
// happen on every cycle, frames back to back with no gap. The final byte's
// transfer loads a frame summary register, then a check stage that also
// forms the pseudo-header partial sums, and then the result register that
// folds the ones' complement sum and compares the UDP checksum. Backpressure
// on the result side stalls the byte side only once all three stages are
// full.
// ----------------------------------------------------------------------------
module udp_ipv4_frame_checker import ufc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  logic       sum_valid;
  logic       sum_ready;
  frame_sum_t sum;

  ufc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  ufc_judge u_judge (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum          (sum),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: tb/udp_ipv4_frame_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_ipv4_frame_checker_test
// Self-checking bench for the UDP/IPv4 receive frame checker.
// ----------------------------------------------------------------------------
// Frames are built in the bench with correct IP and UDP checksums and then
// altered on purpose: truncated, with wrong ethertype, header length, length
// fields or checksums, or replaced by noise. Every byte transfer feeds a
// behavioral predictor of the checker. Each result transfer is compared with
// the oldest predicted result. Both sides idle at random.
// ----------------------------------------------------------------------------
module udp_ipv4_frame_checker_test;
  import ufc_pkg::*;

  localparam int RESULT_LATENCY = 3;
  localparam int CYCLE_LIMIT    = 2000000;

  logic       clk;
  logic       rst          = 1'b1;
  logic       byte_valid   = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item    = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;

  // no random idling on either side while set
  bit         steady = 1'b0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  result_t    expected_results[$];
  result_t    expected_head;
  logic [7:0] frame_bytes[$];

  // predictor state for the frame in flight
  logic [15:0] seen_count  = '0;
  logic [15:0] kind_word   = '0;
  logic [5:0]  ip_hdr_len  = '0;
  logic [15:0] ip_acc      = '0;
  logic [15:0] udp_acc     = '0;
  logic [31:0] ip_src      = '0;
  logic [31:0] ip_dst      = '0;
  logic [15:0] port_src    = '0;
  logic [15:0] udp_len     = '0;
  logic [15:0] udp_sum_rx  = '0;
  logic [7:0]  hi_hold     = '0;

  udp_ipv4_frame_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ones' complement add, end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    int s;
    s = a + b;
    return 16'(s[15:0] + s[16]);
  endfunction

  function automatic status_t judge_frame(input int pos);
    int          len;
    int          hdr;
    logic [15:0] acc;
    hdr = ip_hdr_len;
    if (pos >= COUNT_MAX) return ST_SHORT;
    len = pos + 1;
    if (len < MIN_FRAME_LEN) return ST_SHORT;
    if (kind_word != ETHERTYPE_IPV4) return ST_NOT_IPV4;
    if (hdr < IP_MIN_HDR || len < ETH_HDR_LEN + hdr + UDP_HDR_LEN) return ST_BAD_IHL;
    if (ip_acc != 16'hFFFF) return ST_IP_SUM;
    if (udp_len < UDP_HDR_LEN || ETH_HDR_LEN + hdr + int'(udp_len) > len) return ST_UDP_LEN;
    if (udp_sum_rx != 16'h0000) begin
      acc = udp_acc;
      if (udp_len[0]) acc = fold_add(acc, {hi_hold, 8'h00});
      acc = fold_add(acc, ip_src[31:16]);
      acc = fold_add(acc, ip_src[15:0]);
      acc = fold_add(acc, ip_dst[31:16]);
      acc = fold_add(acc, ip_dst[15:0]);
      acc = fold_add(acc, UDP_PROTOCOL);
      acc = fold_add(acc, udp_len);
      acc = ~acc;
      // a computed sum of zero goes on the wire as all ones
      if (acc == 16'h0000) acc = 16'hFFFF;
      if (acc != udp_sum_rx) return ST_UDP_SUM;
    end
    return ST_OK;
  endfunction

  // called for every byte transfer
  task automatic predict_byte(input logic [7:0] d, input bit fin);
    int         pos;
    int         hdr;
    int         j;
    int         k;
    logic [7:0] v;
    status_t    st;
    result_t    res;
    pos = seen_count;
    if (pos == 12) kind_word = {d, 8'h00};
    else if (pos == 13) kind_word[7:0] = d;
    if (pos == ETH_HDR_LEN) ip_hdr_len = {d[3:0], 2'b00};
    hdr = ip_hdr_len;
    if (pos >= ETH_HDR_LEN && pos < ETH_HDR_LEN + hdr) begin
      j = pos - ETH_HDR_LEN;
      if (j % 2 == 0) hi_hold = d;
      else ip_acc = fold_add(ip_acc, {hi_hold, d});
      if (j >= 12 && j < 16) ip_src = {ip_src[23:0], d};
      else if (j >= 16 && j < 20) ip_dst = {ip_dst[23:0], d};
    end else if (hdr >= IP_MIN_HDR && pos >= ETH_HDR_LEN + hdr) begin
      k = pos - ETH_HDR_LEN - hdr;
      v = d;
      case (k)
        0: port_src = {d, 8'h00};
        1: port_src[7:0] = d;
        4: udp_len = {d, 8'h00};
        5: udp_len[7:0] = d;
        6: begin
          udp_sum_rx = {d, 8'h00};
          v = 8'h00;
        end
        7: begin
          udp_sum_rx[7:0] = d;
          v = 8'h00;
        end
        default: ;
      endcase
      // bytes past the udp length (padding) are not summed
      if (k < 6 || k < int'(udp_len)) begin
        if (k % 2 == 0) hi_hold = v;
        else udp_acc = fold_add(udp_acc, {hi_hold, v});
      end
    end
    if (!fin) begin
      if (seen_count != COUNT_MAX) seen_count++;
    end else begin
      st = judge_frame(pos);
      res = '0;
      res.status = st;
      if (st == ST_OK) begin
        res.source_port    = port_src;
        res.source_address = ip_src;
        res.payload_offset = 7'(ETH_HDR_LEN + hdr + UDP_HDR_LEN);
        res.payload_length = udp_len - 16'(UDP_HDR_LEN);
      end
      expected_results.push_back(res);
      seen_count = '0;
      kind_word  = '0;
      ip_hdr_len = '0;
      ip_acc     = '0;
      udp_acc    = '0;
      ip_src     = '0;
      ip_dst     = '0;
      port_src   = '0;
      udp_len    = '0;
      udp_sum_rx = '0;
      hi_hold    = '0;
    end
  endtask

  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with none expected, actual status=%0d port=%h addr=%h",
                 $time, result.status, result.source_port, result.source_address);
      end else begin
        expected_head = expected_results.pop_front();
        if (result !== expected_head) begin
          mismatch_count++;
          $display("%0t: expected status=%0d port=%h addr=%h offset=%0d length=%0d",
                   $time, expected_head.status, expected_head.source_port,
                   expected_head.source_address, expected_head.payload_offset,
                   expected_head.payload_length);
          $display("%0t: actual   status=%0d port=%h addr=%h offset=%0d length=%0d",
                   $time, result.status, result.source_port, result.source_address,
                   result.payload_offset, result.payload_length);
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input bit fin);
    if (!steady && $urandom_range(99) < 37) begin
      byte_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 37);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: d, last: fin};
    do @(posedge clk); while (!byte_ready);
    predict_byte(d, fin);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // sender holds off until every result is back
  task automatic wait_for_results();
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [15:0] sum_words(input int first, input int n);
    logic [15:0] acc;
    logic [7:0]  lo;
    acc = '0;
    for (int i = 0; i < n; i += 2) begin
      lo = (i + 1 < n) ? frame_bytes[first + i + 1] : 8'h00;
      acc = fold_add(acc, {frame_bytes[first + i], lo});
    end
    return acc;
  endfunction

  task automatic put_word(input int idx, input logic [15:0] w);
    frame_bytes[idx]     = w[15:8];
    frame_bytes[idx + 1] = w[7:0];
  endtask

  task automatic truncate_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endtask

  // ethernet + ipv4 + udp with valid checksums; zero_calc makes the udp sum
  // come out as zero before the all-ones substitution
  task automatic build_frame(input int ihl, input int pay_len, input int pad_len,
                             input bit with_sum, input bit zero_calc);
    int          hdr;
    int          ulen;
    int          udp_at;
    logic [15:0] acc;
    hdr    = ihl * 4;
    ulen   = UDP_HDR_LEN + pay_len;
    udp_at = ETH_HDR_LEN + hdr;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(ETHERTYPE_IPV4[15:8]);
    frame_bytes.push_back(ETHERTYPE_IPV4[7:0]);
    repeat (hdr + ulen + pad_len) frame_bytes.push_back(8'($urandom));
    if (hdr > 0) frame_bytes[ETH_HDR_LEN] = {4'h4, 4'(ihl)};
    if (hdr >= IP_MIN_HDR) frame_bytes[ETH_HDR_LEN + 9] = UDP_PROTOCOL[7:0];
    if (hdr >= 12) begin
      put_word(ETH_HDR_LEN + 10, 16'h0000);
      put_word(ETH_HDR_LEN + 10, ~sum_words(ETH_HDR_LEN, hdr));
    end
    put_word(udp_at + 4, 16'(ulen));
    put_word(udp_at + 6, 16'h0000);
    if (zero_calc && pay_len >= 2) put_word(udp_at + 8, 16'h0000);
    if (with_sum && hdr >= IP_MIN_HDR) begin
      acc = sum_words(udp_at, ulen);
      acc = fold_add(acc, {frame_bytes[26], frame_bytes[27]});
      acc = fold_add(acc, {frame_bytes[28], frame_bytes[29]});
      acc = fold_add(acc, {frame_bytes[30], frame_bytes[31]});
      acc = fold_add(acc, {frame_bytes[32], frame_bytes[33]});
      acc = fold_add(acc, UDP_PROTOCOL);
      acc = fold_add(acc, 16'(ulen));
      if (zero_calc && pay_len >= 2) begin
        put_word(udp_at + 8, ~acc);
        acc = 16'hFFFF;
      end
      acc = ~acc;
      if (acc == 16'h0000) acc = 16'hFFFF;
      put_word(udp_at + 6, acc);
    end
  endtask

  task automatic test_good_frames();
    // minimum length frame
    build_frame(5, 0, 0, 1'b1, 1'b0);
    send_frame();
    // longest header, odd udp length
    build_frame(15, 9, 0, 1'b1, 1'b0);
    send_frame();
    // trailing padding after the udp segment
    build_frame(5, 17, 6, 1'b1, 1'b0);
    send_frame();
    build_frame(6, 4, 0, 1'b1, 1'b1);
    send_frame();
    // stored udp sum of zero means unchecked, even with a damaged payload
    build_frame(5, 30, 0, 1'b0, 1'b0);
    frame_bytes[ETH_HDR_LEN + IP_MIN_HDR + UDP_HDR_LEN] ^= 8'h01;
    send_frame();
    // all-ones source address and port
    build_frame(5, 2, 0, 1'b0, 1'b0);
    put_word(26, 16'hFFFF);
    put_word(28, 16'hFFFF);
    put_word(34, 16'hFFFF);
    put_word(24, 16'h0000);
    put_word(24, ~sum_words(ETH_HDR_LEN, IP_MIN_HDR));
    send_frame();
    wait_for_results();
  endtask

  task automatic test_short_frames();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    build_frame(5, 0, 0, 1'b1, 1'b0);
    truncate_frame(MIN_FRAME_LEN - 1);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_not_ipv4();
    build_frame(5, 4, 0, 1'b1, 1'b0);
    put_word(12, 16'h86DD);
    send_frame();
    build_frame(5, 4, 0, 1'b1, 1'b0);
    frame_bytes[13] = 8'h01;
    send_frame();
    wait_for_results();
  endtask

  task automatic test_bad_header_length();
    build_frame(0, 4, 20, 1'b1, 1'b0);
    send_frame();
    build_frame(4, 4, 10, 1'b1, 1'b0);
    send_frame();
    // header length fine, frame too short to hold it plus a udp header
    build_frame(15, 0, 0, 1'b1, 1'b0);
    truncate_frame(ETH_HDR_LEN + 60 + UDP_HDR_LEN - 1);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_ip_checksum();
    build_frame(5, 4, 0, 1'b1, 1'b0);
    frame_bytes[25] ^= 8'h01;
    send_frame();
    // header of zeros apart from version and length
    build_frame(5, 4, 0, 1'b1, 1'b0);
    for (int j = 1; j < IP_MIN_HDR; j++) frame_bytes[ETH_HDR_LEN + j] = 8'h00;
    send_frame();
    wait_for_results();
  endtask

  task automatic test_udp_length();
    build_frame(5, 4, 0, 1'b1, 1'b0);
    put_word(38, 16'd7);
    send_frame();
    // one byte more than the frame holds
    build_frame(5, 4, 0, 1'b1, 1'b0);
    put_word(38, 16'd13);
    send_frame();
    build_frame(5, 4, 3, 1'b1, 1'b0);
    put_word(38, 16'hFFFF);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_udp_checksum();
    build_frame(5, 6, 0, 1'b1, 1'b0);
    frame_bytes[42] ^= 8'h80;
    send_frame();
    build_frame(5, 3, 0, 1'b1, 1'b0);
    frame_bytes[41] ^= 8'h01;
    send_frame();
    wait_for_results();
  endtask

  task automatic test_random_frames();
    int sent_bytes = 0;
    int frames = 0;
    int mode;
    int ihl;
    int pay;
    int pad;
    int idx;
    while (sent_bytes < 700) begin
      steady = (frames >= 3 && frames < 9);
      ihl = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
      pay = ($urandom_range(9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
      pad = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0;
      build_frame(ihl, pay, pad, $urandom_range(4) != 0, $urandom_range(9) == 0);
      mode = $urandom_range(99);
      if (mode < 65) begin
        // well formed, random content
      end else if (mode < 75) begin
        idx = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[idx] ^= 8'(1 << $urandom_range(7));
      end else if (mode < 83) begin
        truncate_frame($urandom_range(1, frame_bytes.size()));
      end else if (mode < 90) begin
        put_word(ETH_HDR_LEN + ihl * 4 + 4, 16'($urandom_range(0, pay + 16)));
      end else if (mode < 95) begin
        put_word(12, 16'($urandom));
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 90)) frame_bytes.push_back(8'($urandom));
      end
      sent_bytes += frame_bytes.size();
      frames++;
      send_frame();
      if ($urandom_range(15) == 0) wait_for_results();
    end
    steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_good_frames();
    test_short_frames();
    test_not_ipv4();
    test_bad_header_length();
    test_ip_checksum();
    test_udp_length();
    test_udp_checksum();
    test_random_frames();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
